FILE: rtl/core/hdq_pkg.sv
// ----------------------------------------------------------------------------
// hdq_pkg
// shared types and defaults for the handle deque with delete
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdq_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned HandleBits = 16;

  // command codes of a request
  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_POP_HEAD = 2'd1,
    CMD_POP_TAIL = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_e;

  // status codes of a response
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // per-request controls broadcast to every cell, already qualified by the handshake
  typedef struct packed {
    logic append;
    logic pop_head;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/hdq_if.sv
// ----------------------------------------------------------------------------
// hdq_if
// request and response channels of the handle deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hdq_cmd_if #(
  parameter int unsigned HANDLE_BITS = hdq_pkg::HandleBits
);
  logic                   valid;
  logic                   ready;
  hdq_pkg::cmd_e          cmd;
  logic [HANDLE_BITS-1:0] handle;

  modport source (output valid, output cmd, output handle, input ready);
  modport sink   (input valid, input cmd, input handle, output ready);
endinterface

interface hdq_rsp_if #(
  parameter int unsigned HANDLE_BITS = hdq_pkg::HandleBits,
  parameter int unsigned COUNT_BITS  = $clog2(hdq_pkg::Depth + 1)
);
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] out_handle;
  hdq_pkg::status_e       status;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, output out_handle, output status, output count, input ready);
  modport sink   (input valid, input out_handle, input status, input count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hdq_cell.sv
// ----------------------------------------------------------------------------
// hdq_cell
// one slot of the list: holds a handle, compares it, shifts toward the head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdq_cell #(
  parameter int unsigned DEPTH       = hdq_pkg::Depth,
  parameter int unsigned HANDLE_BITS = hdq_pkg::HandleBits,
  parameter int unsigned IDX         = 0
) (
  input  wire                               clk_i,
  input  wire  hdq_pkg::cell_ctrl_t         ctrl_i,
  input  wire  [$clog2(DEPTH + 1)-1:0]      count_i,
  input  wire  [HANDLE_BITS-1:0]            handle_i,
  input  wire  [HANDLE_BITS-1:0]            next_data_i,
  input  wire                               found_i,
  output logic                              found_o,
  output logic                              tail_o,
  output logic [HANDLE_BITS-1:0]            data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Idx     = CntW'(IDX);
  localparam logic [CntW-1:0] IdxNext = CntW'(IDX + 1);

  logic [HANDLE_BITS-1:0] data_q, data_d;
  logic                   live;
  logic                   match;
  logic                   shift;
  logic                   write;

  assign live    = (Idx < count_i);
  assign match   = live && (data_q == handle_i);
  assign found_o = found_i | match;
  // last live slot
  assign tail_o  = live && (IdxNext == count_i);

  // slots at or behind the removed one take their right neighbor
  assign shift = (ctrl_i.pop_head && live) || (ctrl_i.del && found_o && live);
  assign write = ctrl_i.append && (Idx == count_i);

  always_comb begin
    data_d = data_q;
    if (write) begin
      data_d = handle_i;
    end else if (shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/handle_deque_with_remove_core.sv
// ----------------------------------------------------------------------------
// handle_deque_with_remove_core
// ordered list of handles with append, pop head, pop tail and delete by value
// ----------------------------------------------------------------------------
//  channel  | direction | fields                        | handshake
//  ---------+-----------+-------------------------------+--------------
//  cmd_i    | in        | cmd, handle                   | valid/ready
//  rsp_o    | out       | out_handle, status, count     | valid/ready
//
//  every request is done as it is accepted: all cells compare and shift at once,
//  the first-match flag ripples down the cell chain in the same cycle
//  one request per cycle while the response register is empty or being taken
//  the response register is the only stage; a stalled response holds cmd_i
//  reset clears the occupancy and the response valid; slot contents are
//  not cleared, slots beyond the occupancy are never read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module handle_deque_with_remove_core #(
  parameter int unsigned DEPTH       = hdq_pkg::Depth,
  parameter int unsigned HANDLE_BITS = hdq_pkg::HandleBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  hdq_cmd_if.sink     cmd_i,
  hdq_rsp_if.source   rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // occupancy and response register
  logic [CntW-1:0]        occ_q, occ_d;
  logic                   rsp_valid_q;
  logic [HANDLE_BITS-1:0] rsp_handle_q, rsp_handle_d;
  hdq_pkg::status_e       rsp_status_q, rsp_status_d;

  // cell chain wiring
  logic [HANDLE_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH:0]         found;
  logic [DEPTH-1:0]       tail_sel;
  logic [HANDLE_BITS-1:0] tail_data;

  logic                   req_fire;
  logic                   empty;
  logic                   full;
  hdq_pkg::cell_ctrl_t    ctrl;

  // a new request goes in whenever the response slot frees up this cycle
  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = cmd_i.valid && cmd_i.ready;

  assign empty = (occ_q == '0);
  assign full  = (occ_q == FullCnt);

  // cells only act on an accepted request; full/empty cases fall out of
  // the slot index compares inside the cells
  assign ctrl.append   = req_fire && (cmd_i.cmd == hdq_pkg::CMD_APPEND);
  assign ctrl.pop_head = req_fire && (cmd_i.cmd == hdq_pkg::CMD_POP_HEAD);
  assign ctrl.del      = req_fire && (cmd_i.cmd == hdq_pkg::CMD_DELETE);

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] next_data;
    if (i == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    hdq_cell #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS),
      .IDX         (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (occ_q),
      .handle_i    (cmd_i.handle),
      .next_data_i (next_data),
      .found_i     (found[i]),
      .found_o     (found[i+1]),
      .tail_o      (tail_sel[i]),
      .data_o      (cell_data[i])
    );
  end

  // tail select is one-hot (or zero when empty): and-or gather
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | (cell_data[i] & {HANDLE_BITS{tail_sel[i]}});
    end
  end

  // response and next occupancy
  always_comb begin
    occ_d        = occ_q;
    rsp_handle_d = '0;
    rsp_status_d = hdq_pkg::ST_OK;
    case (cmd_i.cmd)
      hdq_pkg::CMD_APPEND: begin
        if (full) begin
          rsp_status_d = hdq_pkg::ST_FULL;
        end else begin
          occ_d = occ_q + CntW'(1);
        end
      end
      hdq_pkg::CMD_POP_HEAD: begin
        if (empty) begin
          rsp_status_d = hdq_pkg::ST_EMPTY;
        end else begin
          rsp_handle_d = cell_data[0];
          occ_d        = occ_q - CntW'(1);
        end
      end
      hdq_pkg::CMD_POP_TAIL: begin
        if (empty) begin
          rsp_status_d = hdq_pkg::ST_EMPTY;
        end else begin
          rsp_handle_d = tail_data;
          occ_d        = occ_q - CntW'(1);
        end
      end
      hdq_pkg::CMD_DELETE: begin
        // a match means the removed handle equals the requested one
        if (found[DEPTH]) begin
          rsp_handle_d = cmd_i.handle;
          occ_d        = occ_q - CntW'(1);
        end else begin
          rsp_status_d = hdq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_status_d = hdq_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        occ_q       <= occ_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload, loaded with each accepted request
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_handle_q <= rsp_handle_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.out_handle = rsp_handle_q;
  assign rsp_o.status     = rsp_status_q;
  // occupancy only moves with a request, so it stays the response count
  assign rsp_o.count      = occ_q;

endmodule

`default_nettype wire

FILE: rtl/core/hdq_checker.sv
// ----------------------------------------------------------------------------
// hdq_checker
// port-level checks for the handle deque, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdq_checker #(
  parameter int unsigned DEPTH       = hdq_pkg::Depth,
  parameter int unsigned HANDLE_BITS = hdq_pkg::HandleBits
) (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           req_valid_i,
  input wire                           req_ready_i,
  input wire                           rsp_valid_i,
  input wire                           rsp_ready_i,
  input wire [HANDLE_BITS-1:0]         rsp_handle_i,
  input wire [1:0]                     rsp_status_i,
  input wire [$clog2(DEPTH + 1)-1:0]   rsp_count_i
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic          req_fire;
  logic          rsp_fire;
  logic [CntW:0] prev_cnt_q;
  logic [CntW:0] cnt_ext;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;
  assign cnt_ext  = {1'b0, rsp_count_i};

  // last delivered count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
    end else if (rsp_fire) begin
      prev_cnt_q <= cnt_ext;
    end
  end

  // stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_handle_i)
      && $stable(rsp_status_i) && $stable(rsp_count_i))
    else $error("response changed while stalled");

  // each accepted request shows a response on the next cycle
  a_req_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_valid_i)
    else $error("request without response");

  // an empty response slot never blocks a request
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request blocked with no pending response");

  // count moves by at most one between delivered responses
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire |-> (cnt_ext == prev_cnt_q) || (cnt_ext == prev_cnt_q + 1'b1)
      || (cnt_ext + 1'b1 == prev_cnt_q))
    else $error("count jumped");

endmodule

bind handle_deque_with_remove_core hdq_checker #(
  .DEPTH       (DEPTH),
  .HANDLE_BITS (HANDLE_BITS)
) u_hdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (cmd_i.valid),
  .req_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_handle_i (rsp_o.out_handle),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.count)
);

`default_nettype wire
